>>> rtl/core/mbrc_pkg.sv
// Package for the Modbus RTU response checker: item, result and config types,
// status and register index codes, and the CRC-16 byte update. No dependencies.
`default_nettype none

package mbrc_pkg;

    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ID       = 3'd1,
        ST_FUNCTION = 3'd2,
        ST_BYTE_CNT = 3'd3,
        ST_ADDRESS  = 3'd4,
        ST_CNT_ECHO = 3'd5,
        ST_CRC      = 3'd6,
        ST_SHORT    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CFG_SLAVE_ADDRESS  = 2'd0,
        CFG_REPLY_KIND     = 2'd1,
        CFG_START_REGISTER = 2'd2,
        CFG_REGISTER_COUNT = 2'd3
    } cfg_index_t;

    localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
    localparam logic [7:0]  FUNC_WRITE_MULTIPLE = 8'h10;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic [7:0]         slave_address;
        logic               reply_kind;
        logic [15:0]        start_register;
        logic [COUNT_W-1:0] eff_count;
        logic [7:0]         frame_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort_frame;
    } in_item_t;

    typedef struct packed {
        logic               word_valid;
        logic [15:0]        register_word;
        logic [COUNT_W-1:0] word_index;
        logic               frame_done;
        status_t            status;
    } result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mbrc_cfg.sv
// Configuration registers of the response checker; derives the clamped
// register count and the expected frame length. Depends on mbrc_pkg.
`default_nettype none

module mbrc_cfg
    import mbrc_pkg::*;
#(
    parameter int MAX_REGISTERS = 125
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    logic [7:0]         slave_address_reg;
    logic               reply_kind_reg;
    logic [15:0]        start_register_reg;
    logic [COUNT_W-1:0] register_count_reg;
    logic [COUNT_W-1:0] eff_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg  <= 8'd1;
            reply_kind_reg     <= 1'b0;
            start_register_reg <= 16'd0;
            register_count_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SLAVE_ADDRESS:  slave_address_reg  <= cfg_data[7:0];
                CFG_REPLY_KIND:     reply_kind_reg     <= cfg_data[0];
                CFG_START_REGISTER: start_register_reg <= cfg_data;
                CFG_REGISTER_COUNT: register_count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (register_count_reg == '0)
            eff_count = COUNT_W'(1);
        else if (register_count_reg > COUNT_W'(MAX_REGISTERS))
            eff_count = COUNT_W'(MAX_REGISTERS);
        else
            eff_count = register_count_reg;
    end

    assign cfg.slave_address  = slave_address_reg;
    assign cfg.reply_kind     = reply_kind_reg;
    assign cfg.start_register = start_register_reg;
    assign cfg.eff_count      = eff_count;
    assign cfg.frame_len      = reply_kind_reg ? 8'd8 : ({eff_count, 1'b0} + 8'd5);

endmodule

`default_nettype wire

>>> rtl/core/mbrc_frame.sv
// Frame state of the response checker: byte position, running CRC, held high
// byte, first error; one byte per step. Depends on mbrc_pkg.
`default_nettype none

module mbrc_frame
    import mbrc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     step,
    input  wire in_item_t item,
    output result_t       res,
    output logic          res_valid
);

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    status_t     err_reg, err_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            high_reg    <= '0;
            err_reg     <= ST_OK;
            crc_low_reg <= '0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            high_reg    <= high_next;
            err_reg     <= err_next;
            crc_low_reg <= crc_low_next;
        end
    end

    always_comb
    begin
        logic [7:0] b;
        status_t    code;
        status_t    final_st;
        logic       mismatch;

        b            = item.rx_byte;
        code         = ST_OK;
        final_st     = ST_OK;
        mismatch     = 1'b0;
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        high_next    = high_reg;
        err_next     = err_reg;
        crc_low_next = crc_low_reg;
        res          = '0;
        res_valid    = 1'b0;

        if (item.abort_frame)
        begin
            res.frame_done = 1'b1;
            res.status     = ST_SHORT;
            res_valid      = 1'b1;
            pos_next       = '0;
            crc_next       = CRC_INIT;
            high_next      = '0;
            err_next       = ST_OK;
            crc_low_next   = '0;
        end
        else if (pos_reg >= cfg.frame_len - 8'd1)
        begin
            final_st = err_reg;
            if (final_st == ST_OK && {b, crc_low_reg} != crc_reg)
                final_st = ST_CRC;
            res.frame_done = 1'b1;
            res.status     = final_st;
            res_valid      = 1'b1;
            pos_next       = '0;
            crc_next       = CRC_INIT;
            high_next      = '0;
            err_next       = ST_OK;
            crc_low_next   = '0;
        end
        else if (pos_reg == cfg.frame_len - 8'd2)
        begin
            crc_low_next = b;
            pos_next     = pos_reg + 8'd1;
        end
        else
        begin
            crc_next = crc16_update(crc_reg, b);
            pos_next = pos_reg + 8'd1;
            if (pos_reg == 8'd0)
            begin
                mismatch = (b != cfg.slave_address);
                code     = ST_ID;
            end
            else if (pos_reg == 8'd1)
            begin
                mismatch = (b != (cfg.reply_kind ? FUNC_WRITE_MULTIPLE
                                                 : FUNC_READ_HOLDING));
                code     = ST_FUNCTION;
            end
            else if (cfg.reply_kind)
            begin
                case (pos_reg)
                    8'd2:
                    begin
                        mismatch = (b != cfg.start_register[15:8]);
                        code     = ST_ADDRESS;
                    end
                    8'd3:
                    begin
                        mismatch = (b != cfg.start_register[7:0]);
                        code     = ST_ADDRESS;
                    end
                    8'd4:
                    begin
                        mismatch = (b != 8'd0);
                        code     = ST_CNT_ECHO;
                    end
                    8'd5:
                    begin
                        mismatch = (b != {1'b0, cfg.eff_count});
                        code     = ST_CNT_ECHO;
                    end
                    default: ;
                endcase
            end
            else if (pos_reg == 8'd2)
            begin
                mismatch = (b != {cfg.eff_count, 1'b0});
                code     = ST_BYTE_CNT;
            end
            else if (pos_reg[0])
            begin
                high_next = b;
            end
            else
            begin
                res.word_valid    = 1'b1;
                res.register_word = {high_reg, b};
                res.word_index    = COUNT_W'(pos_reg[7:1] - 7'd2);
                res_valid         = 1'b1;
            end
            if (mismatch && err_reg == ST_OK)
                err_next = code;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mbrc_out_reg.sv
// Result register of the response checker; drives the master-side stream.
// Depends on mbrc_pkg.
`default_nettype none

module mbrc_out_reg
    import mbrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_t     res,
    output logic             free,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg.status, res_reg.word_index, res_reg.register_word};
    assign m_axis_tuser  = res_reg.word_valid;
    assign m_axis_tlast  = res_reg.frame_done;

endmodule

`default_nettype wire

>>> rtl/core/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: input register, config,
// frame checker and result register. Depends on mbrc_pkg and the mbrc_* modules.
//
//   channel   dir  handshake                payload
//   s_axis    in   s_axis_tvalid/tready     tdata rx_byte, tuser abort_frame
//   m_axis    out  m_axis_tvalid/tready     tdata word/index/status, tuser word_valid,
//                                           tlast frame_done
//   cfg       in   cfg_we                   cfg_index, cfg_data
//
// One byte per cycle while the result register is free; each result is registered there.
// Rate is set by the combinational CRC-16 byte update and the checks beside it.
// Reset returns config to defaults and the frame state to its start.
// A stalled m_axis holds the result register; s_axis keeps taking bytes until
// the input register is also full.
`default_nettype none

module modbus_rtu_response_checker
    import mbrc_pkg::*;
#(
    parameter int MAX_REGISTERS = 125
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  wire logic [0:0]  s_axis_tuser,    // [0] abort_frame
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,    // [15:0] register_word, [22:16] word_index,
                                              // [25:23] status, [31:26] zero
    output logic [0:0]       m_axis_tuser,    // [0] word_valid
    output logic             m_axis_tlast     // frame_done
);

    cfg_t     cfg;
    in_item_t item_reg;
    logic     in_valid_reg, in_valid_next;
    logic     out_free;
    logic     step;
    result_t  res;
    logic     res_valid;

    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.rx_byte     <= s_axis_tdata;
            item_reg.abort_frame <= s_axis_tuser[0];
        end
    end

    mbrc_cfg #(
        .MAX_REGISTERS(MAX_REGISTERS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbrc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .item      (item_reg),
        .res       (res),
        .res_valid (res_valid)
    );

    mbrc_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && res_valid),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_word_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            !m_axis_tlast && m_axis_tdata[25:23] == ST_OK)
        else $error("word result carries frame end or status");

    a_final_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[22:0] == '0)
        else $error("final result carries word data");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a full pipeline");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |=> m_axis_tvalid)
        else $error("result lost on its way to the output register");

endmodule

`default_nettype wire

>>> dv/tb_modbus_rtu_response_checker.sv
// Testbench for modbus_rtu_response_checker: streams Modbus RTU reply bytes,
// good and damaged, across many register settings and checks every word and frame status.
// Depends on mbrc_pkg and the RTL under rtl/core.
`default_nettype none

module tb_modbus_rtu_response_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrc_pkg::*;

    localparam int MAX_REGS = 125;

    typedef enum {
        FLAW_NONE,
        FLAW_ID,
        FLAW_FUNC,
        FLAW_FIELD,
        FLAW_CRC,
        FLAW_CUT,
        FLAW_HEAD
    } reply_flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
    logic [0:0]  s_axis_tuser = '0;    // [0] abort_frame
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] register_word, [22:16] word_index,
                                       // [25:23] status, [31:26] zero
    logic [0:0]  m_axis_tuser;         // [0] word_valid
    logic        m_axis_tlast;

    modbus_rtu_response_checker #(
        .MAX_REGISTERS(MAX_REGS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // transaction settings as last written
    logic [7:0]  exp_slave = 8'd1;
    logic        exp_kind = 1'b0;
    logic [15:0] exp_start = 16'd0;
    logic [6:0]  exp_count = 7'd1;

    // reply parse state
    logic [7:0]  frame_pos = '0;
    logic [15:0] frame_crc = CRC_INIT;
    logic [7:0]  hi_byte = '0;
    status_t     frame_err = ST_OK;
    logic [7:0]  crc_lo_seen = '0;

    in_item_t reply_bytes_q[$];
    result_t  checker_outputs_due[$];

    in_item_t next_byte;
    result_t  seen;
    result_t  want;
    logic     byte_taken = 1'b0;
    logic     calm = 1'b0;
    logic     hold_request = 1'b0;
    int       hold_left = 0;
    int       mismatches = 0;
    int       results_seen = 0;
    int       bytes_sent = 0;
    int       words_checked = 0;
    int       settings_used = 0;
    int       ends_by_status[8] = '{default: 0};

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ octet[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic int regs_in_reply(input logic [6:0] c);
        if (c == 0)
            return 1;
        if (c > MAX_REGS)
            return MAX_REGS;
        return int'(c);
    endfunction

    function automatic void restart_frame();
        frame_pos = '0;
        frame_crc = CRC_INIT;
        hi_byte = '0;
        frame_err = ST_OK;
        crc_lo_seen = '0;
    endfunction

    function automatic void flag_error(input status_t code);
        if (frame_err == ST_OK)
            frame_err = code;
    endfunction

    function automatic void advance_reply_parse(input logic [7:0] b, input logic abort);
        int      n;
        int      len;
        int      pos;
        result_t r;
        n = regs_in_reply(exp_count);
        len = exp_kind ? 8 : 2 * n + 5;
        pos = int'(frame_pos);
        r = '0;
        if (abort)
        begin
            r.frame_done = 1'b1;
            r.status = ST_SHORT;
            checker_outputs_due.push_back(r);
            restart_frame();
        end
        else if (pos >= len - 1)
        begin
            r.frame_done = 1'b1;
            r.status = frame_err;
            if (frame_err == ST_OK && {b, crc_lo_seen} != frame_crc)
                r.status = ST_CRC;
            checker_outputs_due.push_back(r);
            restart_frame();
        end
        else if (pos == len - 2)
        begin
            crc_lo_seen = b;
            frame_pos = frame_pos + 1'b1;
        end
        else
        begin
            frame_crc = crc16_step(frame_crc, b);
            frame_pos = frame_pos + 1'b1;
            if (pos == 0)
            begin
                if (b != exp_slave)
                    flag_error(ST_ID);
            end
            else if (pos == 1)
            begin
                if (b != (exp_kind ? FUNC_WRITE_MULTIPLE : FUNC_READ_HOLDING))
                    flag_error(ST_FUNCTION);
            end
            else if (exp_kind)
            begin
                case (pos)
                    2: if (b != exp_start[15:8]) flag_error(ST_ADDRESS);
                    3: if (b != exp_start[7:0]) flag_error(ST_ADDRESS);
                    4: if (b != 8'(n >> 8)) flag_error(ST_CNT_ECHO);
                    5: if (b != 8'(n)) flag_error(ST_CNT_ECHO);
                    default: ;
                endcase
            end
            else if (pos == 2)
            begin
                if (b != 8'(2 * n))
                    flag_error(ST_BYTE_CNT);
            end
            else if (((pos - 3) & 1) == 0)
                hi_byte = b;
            else
            begin
                r.word_valid = 1'b1;
                r.register_word = {hi_byte, b};
                r.word_index = 7'((pos - 4) >> 1);
                checker_outputs_due.push_back(r);
            end
        end
    endfunction

    function automatic void push_abort();
        reply_bytes_q.push_back('{rx_byte: 8'($urandom), abort_frame: 1'b1});
    endfunction

    // fill: 0 random data, 1 all ones, 2 all zeros; returns bytes queued
    function automatic int queue_reply(input reply_flaw_t flaw, input int fill);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          n;
        int          spot;
        int          keep;
        n = regs_in_reply(exp_count);
        body.push_back(exp_slave);
        body.push_back(exp_kind ? FUNC_WRITE_MULTIPLE : FUNC_READ_HOLDING);
        if (exp_kind)
        begin
            body.push_back(exp_start[15:8]);
            body.push_back(exp_start[7:0]);
            body.push_back(8'(n >> 8));
            body.push_back(8'(n));
        end
        else
        begin
            body.push_back(8'(2 * n));
            for (int i = 0; i < 2 * n; i++)
                body.push_back(fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom));
        end
        case (flaw)
            FLAW_ID:   body[0] = body[0] ^ 8'($urandom_range(255, 1));
            FLAW_FUNC: body[1] = body[1] ^ 8'($urandom_range(255, 1));
            FLAW_FIELD:
            begin
                spot = exp_kind ? $urandom_range(5, 2) : 2;
                body[spot] = body[spot] ^ 8'($urandom_range(255, 1));
            end
            default: ;
        endcase
        crc = CRC_INIT;
        foreach (body[i])
            crc = crc16_step(crc, body[i]);
        if (flaw == FLAW_CRC)
            crc = crc ^ 16'($urandom_range(65535, 1));
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        keep = body.size();
        if (flaw == FLAW_CUT)
            keep = $urandom_range(body.size() - 1, 0);
        else if (flaw == FLAW_HEAD)
            keep = $urandom_range(body.size() - 1, 1);
        for (int i = 0; i < keep; i++)
            reply_bytes_q.push_back('{rx_byte: body[i], abort_frame: 1'b0});
        if (flaw == FLAW_CUT)
        begin
            push_abort();
            keep++;
        end
        return keep;
    endfunction

    // sender: record accepted transaction, mirror register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SLAVE_ADDRESS:  exp_slave = cfg_data[7:0];
                CFG_REPLY_KIND:     exp_kind = cfg_data[0];
                CFG_START_REGISTER: exp_start = cfg_data;
                CFG_REGISTER_COUNT: exp_count = cfg_data[6:0];
                default: ;
            endcase
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            advance_reply_parse(s_axis_tdata, s_axis_tuser[0]);
            byte_taken = 1'b1;
            bytes_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || byte_taken))
        begin
            byte_taken = 1'b0;
            if (reply_bytes_q.size() > 0 && (calm || $urandom_range(99) >= 16))
            begin
                next_byte = reply_bytes_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_byte.rx_byte;
                s_axis_tuser <= next_byte.abort_frame;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 250;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 16);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            seen.word_valid = m_axis_tuser[0];
            seen.register_word = m_axis_tdata[15:0];
            seen.word_index = m_axis_tdata[22:16];
            seen.frame_done = m_axis_tlast;
            seen.status = status_t'(m_axis_tdata[25:23]);
            if (checker_outputs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result wv=%0b word=%h idx=%0d done=%0b st=%0d",
                             $realtime, seen.word_valid, seen.register_word, seen.word_index,
                             seen.frame_done, seen.status);
            end
            else
            begin
                want = checker_outputs_due.pop_front();
                if (want.word_valid)
                    words_checked++;
                if (want.frame_done)
                    ends_by_status[want.status]++;
                if (seen.word_valid !== want.word_valid
                    || seen.register_word !== want.register_word
                    || seen.word_index !== want.word_index
                    || seen.frame_done !== want.frame_done
                    || seen.status !== want.status
                    || m_axis_tdata[31:26] !== 6'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result %0d expected wv=%0b word=%h idx=%0d done=%0b st=%0d",
                                 $realtime, results_seen, want.word_valid, want.register_word,
                                 want.word_index, want.frame_done, want.status);
                        $display("    got wv=%0b word=%h idx=%0d done=%0b st=%0d pad=%h",
                                 seen.word_valid, seen.register_word, seen.word_index,
                                 seen.frame_done, seen.status, m_axis_tdata[31:26]);
                    end
                end
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic program_transaction(input logic [7:0] sa, input logic kind,
                                       input logic [15:0] start, input logic [6:0] count);
        write_reg(CFG_SLAVE_ADDRESS, {8'd0, sa});
        write_reg(CFG_REPLY_KIND, {15'd0, kind});
        write_reg(CFG_START_REGISTER, start);
        write_reg(CFG_REGISTER_COUNT, {9'd0, count});
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (!(reply_bytes_q.size() == 0 && !s_axis_tvalid && checker_outputs_due.size() == 0))
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int          spent;
        int          pick;
        bit          open_frame;
        logic [7:0]  sa;
        logic        kind;
        logic [15:0] start;
        logic [6:0]  count;
        open_frame = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle abort, all-ones word, all-zeros word with bad crc, cut frame
        push_abort();
        void'(queue_reply(FLAW_NONE, 1));
        void'(queue_reply(FLAW_CRC, 2));
        void'(queue_reply(FLAW_CUT, 0));
        drain();

        for (int phase = 0; phase < 30; phase++)
        begin
            sa = phase % 8 == 1 ? 8'h00 : phase % 8 == 2 ? 8'hFF : 8'($urandom);
            kind = $urandom_range(99) < 35;
            start = phase % 5 == 0 ? 16'h0000 : phase % 5 == 1 ? 16'hFFFF : 16'($urandom);
            case (phase)
                3:       count = 7'd0;
                6:       count = 7'd8;
                7:       count = 7'd127;
                13:      count = 7'd125;
                19:      count = 7'd126;
                default: count = 7'($urandom_range(8, 1));
            endcase
            if (phase == 7 || phase == 19)
                kind = 1'b1;
            if (phase == 6 || phase == 13)
                kind = 1'b0;
            calm = phase >= 20 && phase < 24;
            program_transaction(sa, kind, start, count);
            @(posedge clk);
            if (phase == 6)
                hold_request = 1'b1;
            spent = 0;
            while (spent < 8)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    spent += queue_reply(FLAW_NONE, 0);
                else if (pick < 62)
                    spent += queue_reply(FLAW_ID, 0);
                else if (pick < 69)
                    spent += queue_reply(FLAW_FUNC, 0);
                else if (pick < 80)
                    spent += queue_reply(FLAW_FIELD, 0);
                else if (pick < 88)
                    spent += queue_reply(FLAW_CRC, 0);
                else if (pick < 94)
                    spent += queue_reply(FLAW_CUT, 0);
                else
                begin
                    // line noise, then resync
                    repeat ($urandom_range(4, 1))
                    begin
                        reply_bytes_q.push_back('{rx_byte: 8'($urandom), abort_frame: 1'b0});
                        spent++;
                    end
                    push_abort();
                    spent++;
                end
                if (open_frame)
                begin
                    push_abort();
                    open_frame = 1'b0;
                end
            end
            // leave a frame half received across the next register change
            if (phase % 6 == 5)
            begin
                void'(queue_reply(FLAW_HEAD, 0));
                open_frame = 1'b1;
            end
            drain();
        end
        calm = 1'b0;
        drain();

        $display("Run covered %0d reply bytes over %0d register settings; %0d words checked",
                 bytes_sent, settings_used, words_checked);
        $display("Frame ends ok/id/func/bcnt/addr/echo/crc/short: %0d %0d %0d %0d %0d %0d %0d %0d",
                 ends_by_status[ST_OK], ends_by_status[ST_ID], ends_by_status[ST_FUNCTION],
                 ends_by_status[ST_BYTE_CNT], ends_by_status[ST_ADDRESS],
                 ends_by_status[ST_CNT_ECHO], ends_by_status[ST_CRC], ends_by_status[ST_SHORT]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still due", checker_outputs_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/mbrc_pkg.sv
rtl/core/mbrc_cfg.sv
rtl/core/mbrc_frame.sv
rtl/core/mbrc_out_reg.sv
rtl/core/modbus_rtu_response_checker.sv
dv/tb_modbus_rtu_response_checker.sv
